### rtl/iirlp_pkg.sv
`default_nettype none

package iirlp_pkg;

	localparam int ORDER      = 2;
	localparam int LANES      = 4;
	localparam int NUM_FIELDS = 4;

	localparam int SAMPLE_W = 32;
	localparam int COEF_W   = 24;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + 4;
	localparam int FRAC_W   = 20;
	localparam int SHIFT_W  = ACC_W - FRAC_W;

	localparam int NUM_REGS = 7;
	localparam int IDX_W    = 3;
	localparam int ADDR_W   = IDX_W + 2;
	localparam int DATA_W   = 32;

	localparam logic signed [COEF_W-1:0]   B0_RESET   = 24'sd1048576;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef enum logic [IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_B3 = 3'd3,
		REG_A1 = 3'd4,
		REG_A2 = 3'd5,
		REG_A3 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic prime;
	} lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/iirlp_cfg.sv
`default_nettype none

module iirlp_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iirlp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [iirlp_pkg::DATA_W-1:0]  pwdata,
	output logic      [iirlp_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	output iirlp_pkg::coef_t                   b_coef [iirlp_pkg::ORDER+1],
	output iirlp_pkg::coef_t                   a_coef [iirlp_pkg::ORDER]
);

	iirlp_pkg::coef_t                   regs_q [iirlp_pkg::NUM_REGS];
	logic [iirlp_pkg::IDX_W-1:0]        idx;
	logic                               wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[iirlp_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[iirlp_pkg::REG_B0] <= iirlp_pkg::B0_RESET;
			for (int i = int'(iirlp_pkg::REG_B1); i < iirlp_pkg::NUM_REGS; i++) begin
				regs_q[iirlp_pkg::IDX_W'(i)] <= '0;
			end
		end else if (wr_en && (idx <= iirlp_pkg::REG_A3)) begin
			regs_q[idx] <= pwdata[iirlp_pkg::COEF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx <= iirlp_pkg::REG_A3) begin
			prdata = iirlp_pkg::DATA_W'(regs_q[idx]);
		end
	end

	for (genvar k = 0; k <= iirlp_pkg::ORDER; k++) begin : g_b
		assign b_coef[k] = regs_q[iirlp_pkg::IDX_W'(iirlp_pkg::REG_B0) + iirlp_pkg::IDX_W'(k)];
	end

	for (genvar k = 0; k < iirlp_pkg::ORDER; k++) begin : g_a
		assign a_coef[k] = regs_q[iirlp_pkg::IDX_W'(iirlp_pkg::REG_A1) + iirlp_pkg::IDX_W'(k)];
	end

endmodule

`default_nettype wire

### rtl/iirlp_lane.sv
`default_nettype none

module iirlp_lane (
	input  wire logic                 clk,
	input  iirlp_pkg::lane_ctrl_t     ctrl,
	input  iirlp_pkg::coef_t          b_coef [iirlp_pkg::ORDER+1],
	input  iirlp_pkg::coef_t          a_coef [iirlp_pkg::ORDER],
	input  iirlp_pkg::sample_t        sample,
	output iirlp_pkg::sample_t        filtered
);

	localparam int Order = iirlp_pkg::ORDER;
	localparam int ShW   = iirlp_pkg::SHIFT_W;
	localparam int AccW  = iirlp_pkg::ACC_W;

	iirlp_pkg::sample_t xh_q [Order];
	iirlp_pkg::sample_t yh_q [Order];
	iirlp_pkg::sample_t heff [Order];
	iirlp_pkg::prod_t   ffp_d [Order+1];
	iirlp_pkg::prod_t   ffp_s1 [Order+1];
	iirlp_pkg::prod_t   fbp [Order];
	iirlp_pkg::acc_t    acc;
	iirlp_pkg::acc_t    rnd;
	logic signed [ShW-1:0] shifted;
	iirlp_pkg::sample_t y_new;

	always_comb begin
		for (int k = 0; k < Order; k++) begin
			heff[k] = ctrl.prime ? sample : xh_q[k];
		end
		ffp_d[0] = b_coef[0] * sample;
		for (int k = 1; k <= Order; k++) begin
			ffp_d[k] = b_coef[k] * heff[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < Order; k++) begin
			fbp[k] = a_coef[k] * yh_q[k];
		end
		acc = '0;
		for (int k = 0; k <= Order; k++) begin
			acc = acc + AccW'(ffp_s1[k]);
		end
		for (int k = 0; k < Order; k++) begin
			acc = acc - AccW'(fbp[k]);
		end
		rnd     = acc + (AccW'(1) <<< (iirlp_pkg::FRAC_W - 1));
		shifted = ShW'(rnd >>> iirlp_pkg::FRAC_W);
		if (shifted > ShW'(iirlp_pkg::SAMPLE_MAX)) begin
			y_new = iirlp_pkg::SAMPLE_MAX;
		end else if (shifted < ShW'(iirlp_pkg::SAMPLE_MIN)) begin
			y_new = iirlp_pkg::SAMPLE_MIN;
		end else begin
			y_new = shifted[iirlp_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ffp_s1   <= ffp_d;
			xh_q[0]  <= sample;
			for (int k = 1; k < Order; k++) begin
				xh_q[k] <= heff[k-1];
			end
		end
	end

	// prime the feedback taps on the first beat; nothing is in flight then
	always_ff @(posedge clk) begin
		if (ctrl.load && ctrl.prime) begin
			for (int k = 0; k < Order; k++) begin
				yh_q[k] <= sample;
			end
		end else if (ctrl.advance) begin
			yh_q[0] <= y_new;
			for (int k = 1; k < Order; k++) begin
				yh_q[k] <= yh_q[k-1];
			end
		end
	end

	assign filtered = yh_q[0];

endmodule

`default_nettype wire

### rtl/iir_lowpass_filter_multichannel_unit.sv
// Multichannel direct-form-I IIR low-pass filter, shared coefficients.
// Input beat: s_tdata carries one Q16.16 sample per channel, output beat
// m_tdata one filtered Q16.16 sample per channel, saturated to 32 bits.
// Coefficients b0..b3 and a1..a3 (Q3.20) are written over the APB port at
// byte addresses 0x00..0x18; write them only while no beat is in flight.
// The accepting edge loads the first stage; m_tvalid rises at the edge that
// moves the beat on from the first stage into the output stage.
// One beat per cycle while m_tready is high, bound by the per-lane feedback
// path (feedback multiply, sum, round and saturate) in the output stage.
// The first stage holds the feedforward products, the second forms the
// output, which doubles as the newest feedback tap.
// Reset clears the coefficients to b0 = 1.0, all others zero, empties the
// pipeline and unprimes the histories; the first input beat afterwards
// loads every history tap of each channel with its sample.
// When the receiver stalls, the output beat holds and one more input beat
// is taken into the first stage; then s_tready drops until m_tready returns.
`default_nettype none

module iir_lowpass_filter_multichannel_unit (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  s_tvalid,
	output logic                                                       s_tready,
	// sample_0, sample_1, sample_2, sample_3
	input  wire logic [iirlp_pkg::NUM_FIELDS*iirlp_pkg::SAMPLE_W-1:0]  s_tdata,
	output logic                                                       m_tvalid,
	input  wire logic                                                  m_tready,
	// filtered_0, filtered_1, filtered_2, filtered_3
	output logic      [iirlp_pkg::NUM_FIELDS*iirlp_pkg::SAMPLE_W-1:0]  m_tdata,
	input  wire logic                                                  psel,
	input  wire logic                                                  penable,
	input  wire logic                                                  pwrite,
	input  wire logic [iirlp_pkg::ADDR_W-1:0]                          paddr,
	input  wire logic [iirlp_pkg::DATA_W-1:0]                          pwdata,
	output logic      [iirlp_pkg::DATA_W-1:0]                          prdata,
	output logic                                                       pready
);

	localparam int SW = iirlp_pkg::SAMPLE_W;

	iirlp_pkg::coef_t      b_coef [iirlp_pkg::ORDER+1];
	iirlp_pkg::coef_t      a_coef [iirlp_pkg::ORDER];
	iirlp_pkg::lane_ctrl_t ctrl;
	logic                  s1_valid_q;
	logic                  out_valid_q;
	logic                  primed_q;
	logic                  accept;
	logic                  advance;

	iirlp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.b_coef  (b_coef),
		.a_coef  (a_coef)
	);

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	assign ctrl.load    = accept;
	assign ctrl.advance = advance;
	assign ctrl.prime   = !primed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			primed_q    <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				primed_q   <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar j = 0; j < iirlp_pkg::NUM_FIELDS; j++) begin : g_lane
		if (j < iirlp_pkg::LANES) begin : g_on
			iirlp_lane u_lane (
				.clk      (clk),
				.ctrl     (ctrl),
				.b_coef   (b_coef),
				.a_coef   (a_coef),
				.sample   (s_tdata[j*SW +: SW]),
				.filtered (m_tdata[j*SW +: SW])
			);
		end else begin : g_off
			assign m_tdata[j*SW +: SW] = '0;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_prime_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !primed_q) |-> (!s1_valid_q && !out_valid_q))
		else $error("histories primed with a beat in flight");

	a_primed_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> primed_q)
		else $error("primed flag not set after first beat");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stage one beat lost on its way to the output");

endmodule

`default_nettype wire
